/* sv/assert_macros.svh */
// Assertion helpers for the RTL files that check themselves.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* sv/scfp_pkg.sv */
package scfp_pkg;

    localparam int unsigned POS_W = 17;

    localparam logic [7:0] HDR_FIRST   = 8'h53;
    localparam logic [7:0] HDR_SECOND  = 8'h59;
    localparam logic [7:0] TAIL_FIRST  = 8'h54;
    localparam logic [7:0] TAIL_SECOND = 8'h43;

    typedef enum logic
    {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } scfp_kind_t;

    typedef enum logic [1:0]
    {
        ST_OK         = 2'd0,
        ST_INCOMPLETE = 2'd1,
        ST_INVALID    = 2'd2
    } scfp_status_t;

    typedef enum logic [1:0]
    {
        ERR_NONE   = 2'd0,
        ERR_HEADER = 2'd1,
        ERR_TAIL   = 2'd2,
        ERR_SUM    = 2'd3
    } scfp_err_t;

    typedef struct packed
    {
        scfp_kind_t   item_kind;
        logic [7:0]   payload_byte;
        scfp_status_t frame_status;
        scfp_err_t    error_kind;
        logic [7:0]   control_word;
        logic [7:0]   command_word;
        logic [15:0]  payload_length;
    } scfp_result_t;

endpackage

/* sv/scfp_in_if.sv */
interface scfp_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       buffer_end;

    modport source (output valid, output rx_byte, output buffer_end, input ready);
    modport sink (input valid, input rx_byte, input buffer_end, output ready);

endinterface

/* sv/scfp_out_if.sv */
interface scfp_out_if;

    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [1:0]  frame_status;
    logic [1:0]  error_kind;
    logic [7:0]  control_word;
    logic [7:0]  command_word;
    logic [15:0] payload_length;

    modport source
    (
        output valid, output item_kind, output payload_byte, output frame_status,
        output error_kind, output control_word, output command_word,
        output payload_length, input ready
    );
    modport sink
    (
        input valid, input item_kind, input payload_byte, input frame_status,
        input error_kind, input control_word, input command_word,
        input payload_length, output ready
    );

endinterface

/* sv/sum_checked_frame_parser.sv */
// Sum-checked frame parser. Receive bytes enter on rx, one per transfer, with
// buffer_end on the last byte of each buffer; parsing restarts at the first
// byte after every buffer end. A frame is 0x53 0x59, control, command, a
// big-endian 16-bit length n, n payload bytes, a checksum (low 8 bits of the
// sum of all earlier bytes) and 0x54 0x43. Under a good header every payload
// byte is sent on result as it arrives (item_kind 0), then one status
// (item_kind 1): bad header at the ninth byte, else bad tail, else bad
// checksum, else ok with the control, command and length fields; a buffer
// that ends before a decision gives status incomplete instead, and bytes
// after a decision give nothing. The block takes one byte per clock while
// result does not stall: a byte goes into the input register, then the
// per-byte state update is applied and the result register is loaded. The
// state update (position compare against 6+n, 7+n, 8+n and the 8-bit sum)
// is the longest path. rx stalls only while the result register holds an
// item that result.ready has not taken.
`include "assert_macros.svh"

module sum_checked_frame_parser
(
    input  logic              clk,
    input  logic              rst_n,
    scfp_in_if.sink           rx,
    scfp_out_if.source        result
);

    // Input register
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_end_reg;
    logic       s1_fire;

    // Frame state
    logic [scfp_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                       hdr_bad_reg, hdr_bad_next;
    logic [7:0]                 held_control_reg, held_control_next;
    logic [7:0]                 held_command_reg, held_command_next;
    logic [15:0]                held_length_reg, held_length_next;
    logic [7:0]                 sum_reg, sum_next;
    logic                       sum_ok_reg, sum_ok_next;
    logic                       tail1_ok_reg, tail1_ok_next;
    logic                       decided_reg, decided_next;

    // Result register
    logic                   out_valid_reg;
    scfp_pkg::scfp_result_t out_reg;
    logic                   out_free;

    logic                       res_valid;
    scfp_pkg::scfp_result_t     res;
    logic                       decided;
    logic                       is_payload;
    logic                       is_final;
    logic [scfp_pkg::POS_W-1:0] lim_sum;
    logic [scfp_pkg::POS_W-1:0] lim_tail1;
    logic [scfp_pkg::POS_W-1:0] lim_tail2;

    assign out_free = !out_valid_reg || result.ready;
    assign s1_fire  = s1_valid_reg && out_free;
    assign rx.ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            s1_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            s1_byte_reg <= rx.rx_byte;
            s1_end_reg  <= rx.buffer_end;
        end
    end

    always_comb
    begin
        pos_next          = pos_reg;
        hdr_bad_next      = hdr_bad_reg;
        held_control_next = held_control_reg;
        held_command_next = held_command_reg;
        held_length_next  = held_length_reg;
        sum_next          = sum_reg;
        sum_ok_next       = sum_ok_reg;
        tail1_ok_next     = tail1_ok_reg;
        decided_next      = decided_reg;
        decided           = 1'b0;
        is_payload        = 1'b0;
        is_final          = 1'b0;
        res_valid         = 1'b0;
        res               = '0;
        lim_sum           = '0;
        lim_tail1         = '0;
        lim_tail2         = '0;

        if (!decided_reg)
        begin
            if (pos_reg == scfp_pkg::POS_W'(0) && s1_byte_reg != scfp_pkg::HDR_FIRST)
            begin
                hdr_bad_next = 1'b1;
            end
            if (pos_reg == scfp_pkg::POS_W'(1) && s1_byte_reg != scfp_pkg::HDR_SECOND)
            begin
                hdr_bad_next = 1'b1;
            end
            if (pos_reg == scfp_pkg::POS_W'(2))
            begin
                held_control_next = s1_byte_reg;
            end
            if (pos_reg == scfp_pkg::POS_W'(3))
            begin
                held_command_next = s1_byte_reg;
            end
            if (pos_reg == scfp_pkg::POS_W'(4))
            begin
                held_length_next = {s1_byte_reg, 8'h00};
            end
            if (pos_reg == scfp_pkg::POS_W'(5))
            begin
                held_length_next = {held_length_reg[15:8], s1_byte_reg};
            end

            // Length field as it stands after this byte; 8+n fits the position width.
            lim_sum   = scfp_pkg::POS_W'(held_length_next) + scfp_pkg::POS_W'(6);
            lim_tail1 = scfp_pkg::POS_W'(held_length_next) + scfp_pkg::POS_W'(7);
            lim_tail2 = scfp_pkg::POS_W'(held_length_next) + scfp_pkg::POS_W'(8);

            priority if (pos_reg < lim_sum)
            begin
                sum_next = sum_reg + s1_byte_reg;
                if (pos_reg >= scfp_pkg::POS_W'(6))
                begin
                    is_payload = 1'b1;
                end
            end
            else if (pos_reg == lim_sum)
            begin
                sum_ok_next = (s1_byte_reg == sum_reg);
            end
            else if (pos_reg == lim_tail1)
            begin
                tail1_ok_next = (s1_byte_reg == scfp_pkg::TAIL_FIRST);
            end
            else if (pos_reg == lim_tail2)
            begin
                is_final = 1'b1;
            end
            else
            begin
                is_final = 1'b0;
            end

            res.item_kind = scfp_pkg::KIND_STATUS;
            priority if (pos_reg == scfp_pkg::POS_W'(8) && hdr_bad_reg)
            begin
                decided          = 1'b1;
                res.frame_status = scfp_pkg::ST_INVALID;
                res.error_kind   = scfp_pkg::ERR_HEADER;
            end
            else if (is_final)
            begin
                decided = 1'b1;
                priority if (!tail1_ok_reg || s1_byte_reg != scfp_pkg::TAIL_SECOND)
                begin
                    res.frame_status = scfp_pkg::ST_INVALID;
                    res.error_kind   = scfp_pkg::ERR_TAIL;
                end
                else if (!sum_ok_reg)
                begin
                    res.frame_status = scfp_pkg::ST_INVALID;
                    res.error_kind   = scfp_pkg::ERR_SUM;
                end
                else
                begin
                    res.frame_status   = scfp_pkg::ST_OK;
                    res.error_kind     = scfp_pkg::ERR_NONE;
                    res.control_word   = held_control_reg;
                    res.command_word   = held_command_reg;
                    res.payload_length = held_length_reg;
                end
            end
            else if (s1_end_reg)
            begin
                // Buffer ran out first: report incomplete, drop any payload byte.
                res.frame_status = scfp_pkg::ST_INCOMPLETE;
                res.error_kind   = scfp_pkg::ERR_NONE;
            end
            else
            begin
                res.item_kind    = scfp_pkg::KIND_PAYLOAD;
                res.payload_byte = s1_byte_reg;
            end

            res_valid = decided || s1_end_reg || (is_payload && !hdr_bad_next);

            if (decided)
            begin
                decided_next = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + scfp_pkg::POS_W'(1);
            end
        end

        if (s1_end_reg)
        begin
            pos_next          = '0;
            hdr_bad_next      = 1'b0;
            held_control_next = '0;
            held_command_next = '0;
            held_length_next  = '0;
            sum_next          = '0;
            sum_ok_next       = 1'b0;
            tail1_ok_next     = 1'b0;
            decided_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg          <= '0;
            hdr_bad_reg      <= 1'b0;
            held_control_reg <= '0;
            held_command_reg <= '0;
            held_length_reg  <= '0;
            sum_reg          <= '0;
            sum_ok_reg       <= 1'b0;
            tail1_ok_reg     <= 1'b0;
            decided_reg      <= 1'b0;
        end
        else if (s1_fire)
        begin
            pos_reg          <= pos_next;
            hdr_bad_reg      <= hdr_bad_next;
            held_control_reg <= held_control_next;
            held_command_reg <= held_command_next;
            held_length_reg  <= held_length_next;
            sum_reg          <= sum_next;
            sum_ok_reg       <= sum_ok_next;
            tail1_ok_reg     <= tail1_ok_next;
            decided_reg      <= decided_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_fire && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && res_valid && out_free)
        begin
            out_reg <= res;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.item_kind      = out_reg.item_kind;
    assign result.payload_byte   = out_reg.payload_byte;
    assign result.frame_status   = out_reg.frame_status;
    assign result.error_kind     = out_reg.error_kind;
    assign result.control_word   = out_reg.control_word;
    assign result.command_word   = out_reg.command_word;
    assign result.payload_length = out_reg.payload_length;

    `ASSERT_IMPL(a_quiet_after_decision, clk, rst_n, s1_fire && decided_reg, !res_valid)
    `ASSERT_IMPL(a_header_error_at_ninth, clk, rst_n,
        s1_fire && !decided_reg && hdr_bad_reg && pos_reg == scfp_pkg::POS_W'(8),
        res_valid && res.error_kind == scfp_pkg::ERR_HEADER)
    `ASSERT_IMPL(a_accept_when_empty, clk, rst_n, !out_valid_reg, rx.ready)
    `ASSERT_NEXT(a_clear_on_end, clk, rst_n, s1_fire && s1_end_reg,
        pos_reg == '0 && !decided_reg && !hdr_bad_reg)

endmodule
